// ===== sv/cmce_pkg.sv =====
// shared types, indices and rounding helpers for the metric constraint pipeline
`timescale 1ns / 1ps
`default_nettype none

package cmce_pkg;

	// component order of a symmetric 3x3 tensor
	localparam int XX = 0;
	localparam int XY = 1;
	localparam int XZ = 2;
	localparam int YY = 3;
	localparam int YZ = 4;
	localparam int ZZ = 5;
	localparam int NCOMP = 6;

	// register index decoded from paddr[2]
	localparam logic REG_ENABLE = 1'b0;

	// cofactor and determinant unit latency
	localparam int CD_LAT = 4;
	// bits resolved by the cube root search, quotient bits of the inverse, bytes of the divide by three
	localparam int ROOT_BITS = 31;
	localparam int DIV_BITS = 32;
	localparam int D3_STEPS = 8;

	typedef logic [NCOMP-1:0][31:0] sym_t;

	typedef struct packed {
		logic ok;
		sym_t g;
		sym_t a;
		sym_t h;
	} item_t;

	typedef struct packed {
		logic [30:0]  s;
		logic [127:0] q;
		logic [95:0]  s2d;
		logic [63:0]  s1d;
		logic [30:0]  det;
	} root_t;

	typedef struct packed {
		logic [NCOMP-1:0][63:0] rem;
		logic [NCOMP-1:0][31:0] quo;
		logic [NCOMP-1:0]       neg;
		logic [NCOMP-1:0]       ovf;
		logic [30:0]            dv;
	} div_t;

	typedef struct packed {
		logic [NCOMP-1:0][63:0] val;
		logic [NCOMP-1:0][1:0]  rem;
		logic [NCOMP-1:0]       neg;
	} div3_t;

	// n / 2^frac, nearest, ties away from zero
	function automatic logic signed [65:0] rnd(input logic signed [65:0] n, input int frac);
		logic [65:0] mag;
		logic [65:0] q;
		mag = n[65] ? 66'(-n) : 66'(n);
		q = (mag + (66'd1 << (frac - 1))) >> frac;
		return n[65] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/cmce_cof_det.sv =====
// four-stage cofactor and determinant unit for a symmetric 3x3 matrix
`timescale 1ns / 1ps
`default_nettype none

module cmce_cof_det #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  cmce_pkg::sym_t      m,
	output cmce_pkg::sym_t      c,
	output logic [31:0]         det
);

	// cofactor i = m[PA]*m[PB] - m[PC]*m[PD]
	localparam int PA [6] = '{cmce_pkg::YY, cmce_pkg::XZ, cmce_pkg::XY,
		cmce_pkg::XX, cmce_pkg::XY, cmce_pkg::XX};
	localparam int PB [6] = '{cmce_pkg::ZZ, cmce_pkg::YZ, cmce_pkg::YZ,
		cmce_pkg::ZZ, cmce_pkg::XZ, cmce_pkg::YY};
	localparam int PC [6] = '{cmce_pkg::YZ, cmce_pkg::XY, cmce_pkg::XZ,
		cmce_pkg::XZ, cmce_pkg::XX, cmce_pkg::XY};
	localparam int PD [6] = '{cmce_pkg::YZ, cmce_pkg::ZZ, cmce_pkg::YY,
		cmce_pkg::XZ, cmce_pkg::YZ, cmce_pkg::XY};

	logic signed [63:0] pl_s1 [6];
	logic signed [63:0] pr_s1 [6];
	logic [2:0][31:0]   row_s1;
	cmce_pkg::sym_t     cof_s2;
	logic [2:0][31:0]   row_s2;
	logic signed [63:0] dp_s3 [3];
	cmce_pkg::sym_t     cof_s3;
	cmce_pkg::sym_t     cof_s4;
	logic [31:0]        det_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			pl_s1[i] <= $signed(m[PA[i]]) * $signed(m[PB[i]]);
			pr_s1[i] <= $signed(m[PC[i]]) * $signed(m[PD[i]]);
		end
		row_s1 <= {m[cmce_pkg::XZ], m[cmce_pkg::XY], m[cmce_pkg::XX]};

		for (int i = 0; i < 6; i++) begin
			cof_s2[i] <= cmce_pkg::sat32(cmce_pkg::rnd(66'(pl_s1[i]) - 66'(pr_s1[i]), FRAC_BITS));
		end
		row_s2 <= row_s1;

		// first row against its own cofactors
		for (int i = 0; i < 3; i++) begin
			dp_s3[i] <= $signed(row_s2[i]) * $signed(cof_s2[i]);
		end
		cof_s3 <= cof_s2;

		det_s4 <= cmce_pkg::sat32(cmce_pkg::rnd(66'(dp_s3[0]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(dp_s3[1]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(dp_s3[2]), FRAC_BITS));
		cof_s4 <= cof_s3;
	end

	assign c = cof_s4;
	assign det = det_s4;

endmodule

`default_nettype wire

// ===== sv/conformal_metric_constraint_enforce.sv =====
// metric unit-determinant and trace-free enforcement pipeline, top level
// the pipeline takes one item per cycle
// busy is always low: the pipeline never stalls and the receiver cannot hold results off
// cube root takes one bit per stage (31 stages), the inverse one quotient bit per stage (32)
// reset clears the valid line and sets enforce_enable to 1; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module conformal_metric_constraint_enforce #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [31:0]  metric_xx,
	input  wire signed [31:0]  metric_xy,
	input  wire signed [31:0]  metric_xz,
	input  wire signed [31:0]  metric_yy,
	input  wire signed [31:0]  metric_yz,
	input  wire signed [31:0]  metric_zz,
	input  wire signed [31:0]  curv_xx,
	input  wire signed [31:0]  curv_xy,
	input  wire signed [31:0]  curv_xz,
	input  wire signed [31:0]  curv_yy,
	input  wire signed [31:0]  curv_yz,
	input  wire signed [31:0]  curv_zz,
	output logic               done,
	output logic signed [31:0] out_metric_xx,
	output logic signed [31:0] out_metric_xy,
	output logic signed [31:0] out_metric_xz,
	output logic signed [31:0] out_metric_yy,
	output logic signed [31:0] out_metric_yz,
	output logic signed [31:0] out_metric_zz,
	output logic signed [31:0] out_curv_xx,
	output logic signed [31:0] out_curv_xy,
	output logic signed [31:0] out_curv_xz,
	output logic signed [31:0] out_curv_yy,
	output logic signed [31:0] out_curv_yz,
	output logic signed [31:0] out_curv_zz,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [2:0]          paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int NC = cmce_pkg::NCOMP;
	localparam int ST_DET = 1 + cmce_pkg::CD_LAT;
	localparam int ST_ROOT = ST_DET + 1;
	localparam int ST_H = ST_ROOT + cmce_pkg::ROOT_BITS + 1;
	localparam int ST_DH = ST_H + cmce_pkg::CD_LAT;
	localparam int ST_DIVI = ST_DH + 1;
	localparam int ST_LAST = ST_DIVI + cmce_pkg::DIV_BITS + 5 + cmce_pkg::D3_STEPS;
	localparam logic [127:0] TGT = 128'd1 << (4 * FRAC_BITS);

	// largest s with s^3*det <= 2^(4F): running s^3*det, s^2*det, s*det make each
	// trial a sum of shifted terms
	function automatic cmce_pkg::root_t root_step(input cmce_pkg::root_t r, input int b);
		cmce_pkg::root_t o;
		logic [127:0] s2;
		logic [127:0] s1;
		logic [127:0] d;
		logic [127:0] cand;
		o = r;
		s2 = 128'(r.s2d);
		s1 = 128'(r.s1d);
		d = 128'(r.det);
		cand = r.q + (s2 << (b + 1)) + (s2 << b) + (s1 << (2 * b + 1)) + (s1 << (2 * b))
			+ (d << (3 * b));
		if (cand <= TGT) begin
			o.q = cand;
			o.s2d = r.s2d + 96'(s1 << (b + 1)) + 96'(d << (2 * b));
			o.s1d = r.s1d + 64'(d << b);
			o.s[b] = 1'b1;
		end
		return o;
	endfunction

	function automatic cmce_pkg::div_t div_step(input cmce_pkg::div_t r, input int b);
		cmce_pkg::div_t o;
		logic [63:0] sh;
		o = r;
		sh = 64'(r.dv) << b;
		for (int i = 0; i < NC; i++) begin
			if (r.rem[i] >= sh) begin
				o.rem[i] = r.rem[i] - sh;
				o.quo[i][b] = 1'b1;
			end
		end
		return o;
	endfunction

	// one byte of a restoring divide by three, quotient bits replace dividend bits
	function automatic cmce_pkg::div3_t div3_step(input cmce_pkg::div3_t r, input int j);
		cmce_pkg::div3_t o;
		logic [2:0] t;
		logic [1:0] rm;
		int p;
		o = r;
		for (int i = 0; i < NC; i++) begin
			rm = r.rem[i];
			for (int n = 0; n < 8; n++) begin
				p = 63 - 8 * j - n;
				t = {rm, r.val[i][p]};
				if (t >= 3'd3) begin
					t = t - 3'd3;
					o.val[i][p] = 1'b1;
				end else begin
					o.val[i][p] = 1'b0;
				end
				rm = t[1:0];
			end
			o.rem[i] = rm;
		end
		return o;
	endfunction

	logic                        enforce_enable_q;
	logic                        accept;
	cmce_pkg::item_t             entry;
	cmce_pkg::item_t             item_s [1:ST_LAST];
	logic [ST_LAST:1]            vld_s;

	logic [31:0]                 det_g;
	cmce_pkg::sym_t              cof_h;
	logic [31:0]                 det_h;
	logic                        det_pos;
	logic                        dh_pos;
	cmce_pkg::root_t             root_init;
	cmce_pkg::root_t             root_in [cmce_pkg::ROOT_BITS];
	cmce_pkg::root_t             root_s [cmce_pkg::ROOT_BITS];
	logic signed [63:0]          hp_s37 [NC];
	cmce_pkg::div_t              div_init;
	cmce_pkg::div_t              divi_s43;
	cmce_pkg::div_t              div_in [cmce_pkg::DIV_BITS];
	cmce_pkg::div_t              div_s [cmce_pkg::DIV_BITS];
	cmce_pkg::sym_t              inv_s76;
	logic signed [63:0]          tp_s77 [NC];
	logic [31:0]                 trace_s78;
	logic signed [63:0]          th_s79 [NC];
	cmce_pkg::div3_t             d3i_s80;
	cmce_pkg::div3_t             d3_in [cmce_pkg::D3_STEPS];
	cmce_pkg::div3_t             d3_s [cmce_pkg::D3_STEPS];
	cmce_pkg::sym_t              res_g_s89;
	cmce_pkg::sym_t              res_a_s89;
	logic                        done_s89;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == cmce_pkg::REG_ENABLE) begin
			enforce_enable_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == cmce_pkg::REG_ENABLE) ? {31'd0, enforce_enable_q} : 32'd0;

	always_comb begin
		entry.ok = enforce_enable_q;
		entry.g = {metric_zz, metric_yz, metric_yy, metric_xz, metric_xy, metric_xx};
		entry.a = {curv_zz, curv_yz, curv_yy, curv_xz, curv_xy, curv_xx};
		entry.h = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done_s89 <= 1'b0;
		end else begin
			vld_s <= {vld_s[ST_LAST-1:1], accept};
			done_s89 <= vld_s[ST_LAST];
		end
	end

	// item line; flags and the scaled metric join it where they are formed
	always_ff @(posedge clk) begin
		cmce_pkg::item_t nx;
		item_s[1] <= entry;
		for (int k = 2; k <= ST_LAST; k++) begin
			nx = item_s[k-1];
			if (k == ST_ROOT) begin
				nx.ok = item_s[ST_DET].ok & det_pos;
			end
			if (k == ST_H) begin
				for (int i = 0; i < NC; i++) begin
					nx.h[i] = cmce_pkg::sat32(cmce_pkg::rnd(66'(hp_s37[i]), FRAC_BITS));
				end
			end
			if (k == ST_DIVI) begin
				nx.ok = item_s[ST_DH].ok & dh_pos;
			end
			item_s[k] <= nx;
		end
	end

	cmce_cof_det #(.FRAC_BITS(FRAC_BITS)) u_cof_g (
		.clk (clk),
		.m   (item_s[1].g),
		.c   (),
		.det (det_g)
	);

	assign det_pos = $signed(det_g) > 32'sd0;

	always_comb begin
		root_init = '0;
		root_init.det = det_pos ? det_g[30:0] : 31'd0;
	end

	for (genvar j = 0; j < cmce_pkg::ROOT_BITS; j++) begin : g_root
		if (j == 0) begin : g_first
			assign root_in[j] = root_init;
		end else begin : g_next
			assign root_in[j] = root_s[j-1];
		end
		always_ff @(posedge clk) begin
			root_s[j] <= root_step(root_in[j], cmce_pkg::ROOT_BITS - 1 - j);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			hp_s37[i] <= $signed({1'b0, root_s[cmce_pkg::ROOT_BITS-1].s})
				* $signed(item_s[ST_H-2].g[i]);
		end
	end

	cmce_cof_det #(.FRAC_BITS(FRAC_BITS)) u_cof_h (
		.clk (clk),
		.m   (item_s[ST_H].h),
		.c   (cof_h),
		.det (det_h)
	);

	assign dh_pos = $signed(det_h) > 32'sd0;

	// rounded numerator |C|*2^F + dh/2 and saturation check for the inverse
	always_comb begin
		logic [31:0] mag;
		div_init = '0;
		div_init.dv = det_h[30:0];
		for (int i = 0; i < NC; i++) begin
			div_init.neg[i] = cof_h[i][31];
			mag = cof_h[i][31] ? (~cof_h[i] + 32'd1) : cof_h[i];
			div_init.rem[i] = (64'(mag) << FRAC_BITS) + 64'(det_h[30:1]);
			div_init.ovf[i] = div_init.rem[i] >= (64'(det_h[30:0]) << 32);
		end
	end

	always_ff @(posedge clk) begin
		divi_s43 <= div_init;
	end

	for (genvar j = 0; j < cmce_pkg::DIV_BITS; j++) begin : g_div
		if (j == 0) begin : g_first
			assign div_in[j] = divi_s43;
		end else begin : g_next
			assign div_in[j] = div_s[j-1];
		end
		always_ff @(posedge clk) begin
			div_s[j] <= div_step(div_in[j], cmce_pkg::DIV_BITS - 1 - j);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			if (!div_s[cmce_pkg::DIV_BITS-1].neg[i]) begin
				if (div_s[cmce_pkg::DIV_BITS-1].ovf[i] || div_s[cmce_pkg::DIV_BITS-1].quo[i][31]) begin
					inv_s76[i] <= 32'h7fff_ffff;
				end else begin
					inv_s76[i] <= div_s[cmce_pkg::DIV_BITS-1].quo[i];
				end
			end else if (div_s[cmce_pkg::DIV_BITS-1].ovf[i]
				|| div_s[cmce_pkg::DIV_BITS-1].quo[i] > 32'h8000_0000) begin
				inv_s76[i] <= 32'h8000_0000;
			end else begin
				inv_s76[i] <= ~div_s[cmce_pkg::DIV_BITS-1].quo[i] + 32'd1;
			end
		end

		for (int i = 0; i < NC; i++) begin
			tp_s77[i] <= $signed(inv_s76[i]) * $signed(item_s[ST_LAST-12].a[i]);
		end

		// off-diagonal terms count twice
		trace_s78 <= cmce_pkg::sat32(cmce_pkg::rnd(66'(tp_s77[cmce_pkg::XX]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(tp_s77[cmce_pkg::YY]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(tp_s77[cmce_pkg::ZZ]), FRAC_BITS)
			+ ((cmce_pkg::rnd(66'(tp_s77[cmce_pkg::XY]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(tp_s77[cmce_pkg::XZ]), FRAC_BITS)
			+ cmce_pkg::rnd(66'(tp_s77[cmce_pkg::YZ]), FRAC_BITS)) <<< 1));

		for (int i = 0; i < NC; i++) begin
			th_s79[i] <= $signed(trace_s78) * $signed(item_s[ST_LAST-10].h[i]);
		end
	end

	// divide by 3*2^F, rounded: a shift with a bias of 1.5*2^F followed by a truncating divide by three
	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			d3i_s80.neg[i] <= th_s79[i][63];
			d3i_s80.rem[i] <= 2'd0;
			d3i_s80.val[i] <= ((th_s79[i][63] ? 64'(-th_s79[i]) : 64'(th_s79[i]))
				+ (64'd3 << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
	end

	for (genvar j = 0; j < cmce_pkg::D3_STEPS; j++) begin : g_d3
		if (j == 0) begin : g_first
			assign d3_in[j] = d3i_s80;
		end else begin : g_next
			assign d3_in[j] = d3_s[j-1];
		end
		always_ff @(posedge clk) begin
			d3_s[j] <= div3_step(d3_in[j], j);
		end
	end

	always_ff @(posedge clk) begin
		logic signed [65:0] corr;
		for (int i = 0; i < NC; i++) begin
			corr = d3_s[cmce_pkg::D3_STEPS-1].neg[i]
				? -$signed(66'(d3_s[cmce_pkg::D3_STEPS-1].val[i]))
				: $signed(66'(d3_s[cmce_pkg::D3_STEPS-1].val[i]));
			if (item_s[ST_LAST].ok) begin
				res_g_s89[i] <= item_s[ST_LAST].h[i];
				res_a_s89[i] <= cmce_pkg::sat32(66'($signed(item_s[ST_LAST].a[i])) - corr);
			end else begin
				res_g_s89[i] <= item_s[ST_LAST].g[i];
				res_a_s89[i] <= item_s[ST_LAST].a[i];
			end
		end
	end

	assign done = done_s89;
	assign out_metric_xx = res_g_s89[cmce_pkg::XX];
	assign out_metric_xy = res_g_s89[cmce_pkg::XY];
	assign out_metric_xz = res_g_s89[cmce_pkg::XZ];
	assign out_metric_yy = res_g_s89[cmce_pkg::YY];
	assign out_metric_yz = res_g_s89[cmce_pkg::YZ];
	assign out_metric_zz = res_g_s89[cmce_pkg::ZZ];
	assign out_curv_xx = res_a_s89[cmce_pkg::XX];
	assign out_curv_xy = res_a_s89[cmce_pkg::XY];
	assign out_curv_xz = res_a_s89[cmce_pkg::XZ];
	assign out_curv_yy = res_a_s89[cmce_pkg::YY];
	assign out_curv_yz = res_a_s89[cmce_pkg::YZ];
	assign out_curv_zz = res_a_s89[cmce_pkg::ZZ];

endmodule

`default_nettype wire
